[rtl/assert_macros.svh]
// Assertion macros for the deque RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset
`define BDQ_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("deque check failed");

// Check that a trigger implies a consequence in the following cycle
`define BDQ_ASSERT_NEXT(lbl, trig, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error("deque check failed");

`endif

[rtl/bdq_pkg.sv]
// Types and constants for the bounded deque
package bdq_pkg;

    localparam int DEPTH   = 16;
    localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int DATA_W  = 32;
    localparam int ACT_W   = 3;
    localparam int CAP_W   = 5;
    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);
    localparam logic [DATA_W-1:0] EMPTY_MARK = '1;

    typedef enum logic [ACT_W-1:0] {
        ACT_NONE       = 3'd0,
        ACT_PUSH_FRONT = 3'd1,
        ACT_PUSH_BACK  = 3'd2,
        ACT_POP_FRONT  = 3'd3,
        ACT_POP_BACK   = 3'd4
    } action_t;

    typedef enum logic [1:0] {
        CELL_HOLD      = 2'd0,
        CELL_FROM_PREV = 2'd1,
        CELL_FROM_NEXT = 2'd2,
        CELL_LOAD      = 2'd3
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
    } cell_ctrl_t;

endpackage

[rtl/bdq_in_if.sv]
// Input channel: action and value with valid/ready
interface bdq_in_if;
    logic                          valid;
    logic                          ready;
    logic [bdq_pkg::ACT_W-1:0]     action;
    logic signed [bdq_pkg::DATA_W-1:0] value;

    modport source (output valid, output action, output value, input ready);
    modport sink   (input valid, input action, input value, output ready);
endinterface

[rtl/bdq_out_if.sv]
// Result channel: status and end entries with valid/ready
interface bdq_out_if;
    logic                          valid;
    logic                          ready;
    logic                          ok;
    logic signed [bdq_pkg::DATA_W-1:0] front_value;
    logic signed [bdq_pkg::DATA_W-1:0] rear_value;
    logic                          empty_res;
    logic                          full_res;

    modport source (output valid, output ok, output front_value, output rear_value,
                    output empty_res, output full_res, input ready);
    modport sink   (input valid, input ok, input front_value, input rear_value,
                    input empty_res, input full_res, output ready);
endinterface

[rtl/bdq_cell.sv]
// One storage cell of the deque shift row
module bdq_cell (
    input  logic                        clk,
    input  bdq_pkg::cell_ctrl_t         ctrl,
    input  logic [bdq_pkg::DATA_W-1:0]  prev_value,
    input  logic [bdq_pkg::DATA_W-1:0]  next_value,
    input  logic [bdq_pkg::DATA_W-1:0]  load_value,
    output logic [bdq_pkg::DATA_W-1:0]  value,
    output logic [bdq_pkg::DATA_W-1:0]  value_next
);
    import bdq_pkg::*;

    logic [DATA_W-1:0] value_reg;

    always_comb
    begin
        unique case (ctrl.op)
            CELL_HOLD:      value_next = value_reg;
            CELL_FROM_PREV: value_next = prev_value;
            CELL_FROM_NEXT: value_next = next_value;
            CELL_LOAD:      value_next = load_value;
            default:        value_next = value_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

[rtl/bounded_deque_core.sv]
// Top level of the bounded deque: cell row, count and result register
//
// Usage:
//   in_ch carries one action (none, push front, push back, pop front,
//   pop back) and a 32-bit value per transfer. out_ch returns exactly one
//   result per input transfer: ok, the front and rear entries after the
//   action (-1 when empty), and the empty and full flags.
//   cfg_write_en/cfg_write_data set the capacity; values above the
//   storage depth act as the depth. Write it only while the block is idle.
//   The result is registered and appears in the cycle after the transfer.
//   Throughput: one item per cycle unless out_ch stalls; entries move
//   one cell per cycle along the row, each action completing when taken.
//   Reset empties the deque and sets capacity to 16; out_ch goes invalid.
//   When the receiver stalls, the result register holds and in_ch.ready
//   drops until the result is taken; a result leaving frees the register
//   for a new transfer in the same cycle.
`include "assert_macros.svh"

module bounded_deque_core (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_write_en,
    input  logic [bdq_pkg::CAP_W-1:0]  cfg_write_data,
    bdq_in_if.sink                     in_ch,
    bdq_out_if.source                  out_ch
);
    import bdq_pkg::*;

    logic [CAP_W-1:0]  cap_reg;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  cap_eff;
    logic              full_now;
    logic              ok_comb;
    logic              in_xfer;
    logic              out_valid_reg;
    logic              ok_reg;
    logic [DATA_W-1:0] front_reg, rear_reg;
    logic              empty_reg, full_reg;
    logic [IDX_W-1:0]  rear_idx;
    action_t           act;
    logic              do_push_front, do_push_back, do_pop_front, do_pop_back;

    cell_ctrl_t        cell_ctrl  [DEPTH];
    logic [DATA_W-1:0] cell_value [DEPTH];
    logic [DATA_W-1:0] cell_next  [DEPTH];

    assign act      = action_t'(in_ch.action);
    assign in_xfer  = in_ch.valid && in_ch.ready;
    assign in_ch.ready = !out_valid_reg || out_ch.ready;

    assign cap_eff  = (int'(cap_reg) > DEPTH) ? CNT_W'(DEPTH) : CNT_W'(cap_reg);
    assign full_now = count_reg >= cap_eff;

    always_comb
    begin
        unique case (act)
            ACT_NONE:       ok_comb = 1'b1;
            ACT_PUSH_FRONT: ok_comb = !full_now;
            ACT_PUSH_BACK:  ok_comb = !full_now;
            ACT_POP_FRONT:  ok_comb = count_reg != '0;
            ACT_POP_BACK:   ok_comb = count_reg != '0;
            default:        ok_comb = 1'b0;
        endcase
    end

    assign do_push_front = in_xfer && ok_comb && (act == ACT_PUSH_FRONT);
    assign do_push_back  = in_xfer && ok_comb && (act == ACT_PUSH_BACK);
    assign do_pop_front  = in_xfer && ok_comb && (act == ACT_POP_FRONT);
    assign do_pop_back   = in_xfer && ok_comb && (act == ACT_POP_BACK);

    always_comb
    begin
        priority if (do_push_front || do_push_back)
            count_next = count_reg + CNT_W'(1);
        else if (do_pop_front || do_pop_back)
            count_next = count_reg - CNT_W'(1);
        else
            count_next = count_reg;
    end

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [DATA_W-1:0] prev_v;
        logic [DATA_W-1:0] next_v;

        if (i == 0)
        begin : g_first
            assign prev_v = in_ch.value;
        end
        else
        begin : g_mid
            assign prev_v = cell_value[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign next_v = cell_value[i];
        end
        else
        begin : g_body
            assign next_v = cell_value[i+1];
        end

        always_comb
        begin
            priority if (do_push_front)
                cell_ctrl[i].op = CELL_FROM_PREV;
            else if (do_pop_front)
                cell_ctrl[i].op = CELL_FROM_NEXT;
            else if (do_push_back && (count_reg == CNT_W'(i)))
                cell_ctrl[i].op = CELL_LOAD;
            else
                cell_ctrl[i].op = CELL_HOLD;
        end

        bdq_cell u_cell (
            .clk        (clk),
            .ctrl       (cell_ctrl[i]),
            .prev_value (prev_v),
            .next_value (next_v),
            .load_value (in_ch.value),
            .value      (cell_value[i]),
            .value_next (cell_next[i])
        );
    end

    assign rear_idx = IDX_W'(count_next - CNT_W'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= CAP_RESET;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
                cap_reg <= cfg_write_data;
            count_reg <= count_next;
            if (in_xfer)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            ok_reg    <= ok_comb;
            empty_reg <= count_next == '0;
            full_reg  <= count_next >= cap_eff;
            front_reg <= (count_next == '0) ? EMPTY_MARK : cell_next[0];
            rear_reg  <= (count_next == '0) ? EMPTY_MARK : cell_next[rear_idx];
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.ok          = ok_reg;
    assign out_ch.front_value = front_reg;
    assign out_ch.rear_value  = rear_reg;
    assign out_ch.empty_res   = empty_reg;
    assign out_ch.full_res    = full_reg;

    `BDQ_ASSERT_ALWAYS(a_count_in_range, int'(count_reg) <= DEPTH)
    `BDQ_ASSERT_NEXT(a_xfer_gives_result, in_xfer, out_valid_reg)
    `BDQ_ASSERT_NEXT(a_push_counts, do_push_front || do_push_back, count_reg == $past(count_reg) + CNT_W'(1))
    `BDQ_ASSERT_NEXT(a_refused_holds, in_xfer && !ok_comb, count_reg == $past(count_reg))

endmodule
